>>> hw/rtl/mtc_pkg.sv
// Package for the markup token classifier: transaction types, token state,
// kind and role codes, and the per-character token body function.
// No dependencies.
package mtc_pkg;

	localparam int unsigned MaxResults = 4;

	localparam logic [2:0] KIND_TEXT    = 3'd0;
	localparam logic [2:0] KIND_TAG     = 3'd1;
	localparam logic [2:0] KIND_ENDTAG  = 3'd2;
	localparam logic [2:0] KIND_SINGLE  = 3'd3;
	localparam logic [2:0] KIND_COMMENT = 3'd4;
	localparam logic [2:0] KIND_DOCTYPE = 3'd5;
	localparam logic [2:0] KIND_PI      = 3'd6;
	localparam logic [2:0] KIND_EOF     = 3'd7;

	localparam logic [1:0] ROLE_TEXT = 2'd0;
	localparam logic [1:0] ROLE_OPEN = 2'd1;
	localparam logic [1:0] ROLE_BODY = 2'd2;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;

	localparam logic [15:0] PAIR_LT_BANG = 16'h3C21;
	localparam logic [15:0] PAIR_LT      = 16'h003C;
	localparam logic [15:0] PAIR_DASHES  = 16'h2D2D;
	localparam logic [15:0] PAIR_SLASH_GT = 16'h2F3E;

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_TEXT = 6'b000010,
		MODE_P1   = 6'b000100,
		MODE_P2   = 6'b001000,
		MODE_P3   = 6'b010000,
		MODE_BODY = 6'b100000
	} mode_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       has_char;
		logic [1:0] role;
		logic       in_name;
		logic [2:0] kind;
		logic       token_done;
		logic [1:0] close_len;
		logic       name_cut;
		logic       quoted;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [2:0]  cur_kind;
		logic [15:0] recent_pair;
		logic        quote_open;
		logic        quote_is_double;
		logic        name_active;
		logic [1:0]  name_count;
		logic [15:0] name_tail;
	} tok_t;

	typedef struct packed {
		tok_t    tok;
		result_t res;
		logic    match;
	} body_ret_t;

	typedef struct packed {
		result_t [MaxResults-1:0] res;
		logic [2:0]               cnt;
	} step_out_t;

	localparam tok_t TOK_CLEAR = '{
		cur_kind: KIND_TEXT, recent_pair: 16'h0000, quote_open: 1'b0,
		quote_is_double: 1'b0, name_active: 1'b1, name_count: 2'd0,
		name_tail: 16'h0000
	};

	function automatic result_t mk_res(logic [7:0] ch, logic has, logic [1:0] role,
			logic nm, logic [2:0] kind, logic done, logic [1:0] clen, logic cut,
			logic q);
		result_t r;
		r.char_out   = ch;
		r.has_char   = has;
		r.role       = role;
		r.in_name    = nm;
		r.kind       = kind;
		r.token_done = done;
		r.close_len  = clen;
		r.name_cut   = cut;
		r.quoted     = q;
		r.run_last   = 1'b0;
		return r;
	endfunction

	function automatic result_t mk_mark(logic [2:0] kind);
		return mk_res(8'h00, 1'b0, ROLE_TEXT, 1'b0, kind, 1'b1, 2'd0, 1'b0, 1'b0);
	endfunction

	function automatic result_t mk_open(logic [7:0] ch, logic [2:0] kind, logic done);
		return mk_res(ch, 1'b1, ROLE_OPEN, 1'b0, kind, done, 2'd0, 1'b0, 1'b0);
	endfunction

	function automatic tok_t tok_begin(logic [2:0] kind, logic [15:0] pair);
		tok_t t;
		t = TOK_CLEAR;
		t.cur_kind = kind;
		t.recent_pair = pair;
		return t;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == 8'h85 || c == 8'hA0;
	endfunction

	function automatic logic [1:0] dlm_len(logic [2:0] k);
		logic [1:0] len;
		unique case (k) inside
			KIND_TAG, KIND_ENDTAG, KIND_DOCTYPE: len = 2'd1;
			KIND_COMMENT: len = 2'd3;
			KIND_PI: len = 2'd2;
			default: len = 2'd0;
		endcase
		return len;
	endfunction

	// second-to-last byte of the closing delimiter
	function automatic logic [7:0] dlm_mid(logic [2:0] k);
		logic [7:0] d;
		unique case (k)
			KIND_COMMENT: d = CH_DASH;
			KIND_PI: d = CH_QMARK;
			default: d = 8'h00;
		endcase
		return d;
	endfunction

	// one content byte of an open token
	function automatic body_ret_t body_char(tok_t s, logic [7:0] c);
		body_ret_t r;
		tok_t n;
		logic [2:0] k;
		logic [1:0] len;
		logic [7:0] d1;
		logic [7:0] prev;
		logic app;
		logic match;
		logic cut;
		k = s.cur_kind;
		len = dlm_len(k);
		d1 = dlm_mid(k);
		prev = s.recent_pair[7:0];
		n = s;
		app = 1'b0;
		match = 1'b0;
		cut = 1'b0;
		if (s.name_active) begin
			if (!is_space(c)) begin
				app = 1'b1;
				n.name_tail = {s.name_tail[7:0], c};
				if (s.name_count != 2'd3) begin
					n.name_count = s.name_count + 2'd1;
				end
			end else begin
				n.name_active = (s.name_count == 2'd0);
			end
		end
		if (k != KIND_COMMENT) begin
			if (!s.quote_open) begin
				if (c == CH_SQ || c == CH_DQ) begin
					n.quote_open = 1'b1;
					n.quote_is_double = (c == CH_DQ);
				end
			end else begin
				n.quote_open = (c != (s.quote_is_double ? CH_DQ : CH_SQ));
			end
		end
		if ((k == KIND_COMMENT || !n.quote_open) && len != 2'd0) begin
			match = c == CH_GT && (len < 2'd2 || prev == d1) &&
				(len < 2'd3 || s.recent_pair[15:8] == CH_DASH);
		end
		n.recent_pair = {s.recent_pair[7:0], c};
		if (match) begin
			if (app) begin
				cut = s.name_count >= (len - 2'd1) &&
					(len < 2'd2 || s.name_tail[7:0] == d1) &&
					(len < 2'd3 || s.name_tail[15:8] == CH_DASH);
			end else begin
				cut = len < 2'd3 && n.name_count >= len && n.name_tail[7:0] == CH_GT &&
					(len < 2'd2 || n.name_tail[15:8] == d1);
			end
			if (k == KIND_TAG && prev == CH_SLASH) begin
				k = KIND_SINGLE;
			end
		end
		r.res = mk_res(c, 1'b1, ROLE_BODY, app, k, match, match ? len : 2'd0, cut,
			n.quote_open);
		r.tok = match ? TOK_CLEAR : n;
		r.match = match;
		return r;
	endfunction

endpackage

>>> hw/rtl/mtc_core.sv
// Token state registers and the per-transaction step logic: from the
// registered input item, builds up to four results and the next state.
// Depends on mtc_pkg.
module mtc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  mtc_pkg::item_t     item,
	output mtc_pkg::step_out_t step
);

	mtc_pkg::mode_t mode_q;
	mtc_pkg::mode_t mode_d;
	mtc_pkg::tok_t  tok_q;
	mtc_pkg::tok_t  tok_d;
	mtc_pkg::body_ret_t b_tag;
	mtc_pkg::body_ret_t b_doc;
	mtc_pkg::body_ret_t b_dash;
	mtc_pkg::body_ret_t b_dash2;
	mtc_pkg::body_ret_t b_body;
	logic [7:0] b;
	logic [2:0] pk;
	logic [2:0] fk;
	logic [2:0] cnt_m1;

	assign b = item.data_byte;

	always_comb begin
		b_tag   = mtc_pkg::body_char(mtc_pkg::tok_begin(mtc_pkg::KIND_TAG, mtc_pkg::PAIR_LT), b);
		b_doc   = mtc_pkg::body_char(
			mtc_pkg::tok_begin(mtc_pkg::KIND_DOCTYPE, mtc_pkg::PAIR_LT_BANG), b);
		b_dash  = mtc_pkg::body_char(
			mtc_pkg::tok_begin(mtc_pkg::KIND_DOCTYPE, mtc_pkg::PAIR_LT_BANG), mtc_pkg::CH_DASH);
		b_dash2 = mtc_pkg::body_char(b_dash.tok, b);
		b_body  = mtc_pkg::body_char(tok_q, b);
	end

	always_comb begin
		pk = (b == mtc_pkg::CH_SLASH) ? mtc_pkg::KIND_ENDTAG : mtc_pkg::KIND_PI;
		fk = tok_q.cur_kind;
		if (fk == mtc_pkg::KIND_TAG && tok_q.recent_pair == mtc_pkg::PAIR_SLASH_GT) begin
			fk = mtc_pkg::KIND_SINGLE;
		end
	end

	always_comb begin
		step = '0;
		tok_d = tok_q;
		mode_d = mode_q;
		if (item.command) begin
			tok_d = mtc_pkg::TOK_CLEAR;
			mode_d = mtc_pkg::MODE_IDLE;
			unique case (mode_q)
				mtc_pkg::MODE_TEXT: begin
					step.res[0] = mtc_pkg::mk_mark(mtc_pkg::KIND_TEXT);
					step.res[1] = mtc_pkg::mk_mark(mtc_pkg::KIND_EOF);
					step.cnt = 3'd2;
				end
				mtc_pkg::MODE_P1: begin
					step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_TAG, 1'b1);
					step.res[1] = mtc_pkg::mk_mark(mtc_pkg::KIND_EOF);
					step.cnt = 3'd2;
				end
				mtc_pkg::MODE_P2: begin
					step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_DOCTYPE, 1'b0);
					step.res[1] = mtc_pkg::mk_open(mtc_pkg::CH_BANG, mtc_pkg::KIND_DOCTYPE, 1'b1);
					step.res[2] = mtc_pkg::mk_mark(mtc_pkg::KIND_EOF);
					step.cnt = 3'd3;
				end
				mtc_pkg::MODE_P3: begin
					step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_DOCTYPE, 1'b0);
					step.res[1] = mtc_pkg::mk_open(mtc_pkg::CH_BANG, mtc_pkg::KIND_DOCTYPE, 1'b0);
					step.res[2] = b_dash.res;
					step.res[2].token_done = 1'b1;
					step.res[3] = mtc_pkg::mk_mark(mtc_pkg::KIND_EOF);
					step.cnt = 3'd4;
				end
				mtc_pkg::MODE_BODY: begin
					step.res[0] = mtc_pkg::mk_mark(fk);
					step.res[1] = mtc_pkg::mk_mark(mtc_pkg::KIND_EOF);
					step.cnt = 3'd2;
				end
				default: begin
					step.res[0] = mtc_pkg::mk_mark(mtc_pkg::KIND_EOF);
					step.cnt = 3'd1;
				end
			endcase
		end else begin
			unique case (mode_q)
				mtc_pkg::MODE_TEXT: begin
					if (b == mtc_pkg::CH_LT) begin
						step.res[0] = mtc_pkg::mk_mark(mtc_pkg::KIND_TEXT);
						mode_d = mtc_pkg::MODE_P1;
					end else begin
						step.res[0] = mtc_pkg::mk_res(b, 1'b1, mtc_pkg::ROLE_TEXT, 1'b0,
							mtc_pkg::KIND_TEXT, 1'b0, 2'd0, 1'b0, 1'b0);
					end
					step.cnt = 3'd1;
				end
				mtc_pkg::MODE_P1: begin
					if (b == mtc_pkg::CH_BANG) begin
						mode_d = mtc_pkg::MODE_P2;
					end else if (b == mtc_pkg::CH_SLASH || b == mtc_pkg::CH_QMARK) begin
						step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, pk, 1'b0);
						step.res[1] = mtc_pkg::mk_open(b, pk, 1'b0);
						step.cnt = 3'd2;
						tok_d = mtc_pkg::tok_begin(pk, {mtc_pkg::CH_LT, b});
						mode_d = mtc_pkg::MODE_BODY;
					end else begin
						step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_TAG, 1'b0);
						step.res[1] = b_tag.res;
						step.cnt = 3'd2;
						tok_d = b_tag.tok;
						mode_d = b_tag.match ? mtc_pkg::MODE_IDLE : mtc_pkg::MODE_BODY;
					end
				end
				mtc_pkg::MODE_P2: begin
					if (b == mtc_pkg::CH_DASH) begin
						mode_d = mtc_pkg::MODE_P3;
					end else begin
						step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_DOCTYPE, 1'b0);
						step.res[1] = mtc_pkg::mk_open(mtc_pkg::CH_BANG, mtc_pkg::KIND_DOCTYPE, 1'b0);
						step.res[2] = b_doc.res;
						step.cnt = 3'd3;
						tok_d = b_doc.tok;
						mode_d = b_doc.match ? mtc_pkg::MODE_IDLE : mtc_pkg::MODE_BODY;
					end
				end
				mtc_pkg::MODE_P3: begin
					if (b == mtc_pkg::CH_DASH) begin
						step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_COMMENT, 1'b0);
						step.res[1] = mtc_pkg::mk_open(mtc_pkg::CH_BANG, mtc_pkg::KIND_COMMENT, 1'b0);
						step.res[2] = mtc_pkg::mk_open(mtc_pkg::CH_DASH, mtc_pkg::KIND_COMMENT, 1'b0);
						step.res[3] = mtc_pkg::mk_open(mtc_pkg::CH_DASH, mtc_pkg::KIND_COMMENT, 1'b0);
						tok_d = mtc_pkg::tok_begin(mtc_pkg::KIND_COMMENT, mtc_pkg::PAIR_DASHES);
						mode_d = mtc_pkg::MODE_BODY;
					end else begin
						step.res[0] = mtc_pkg::mk_open(mtc_pkg::CH_LT, mtc_pkg::KIND_DOCTYPE, 1'b0);
						step.res[1] = mtc_pkg::mk_open(mtc_pkg::CH_BANG, mtc_pkg::KIND_DOCTYPE, 1'b0);
						step.res[2] = b_dash.res;
						step.res[3] = b_dash2.res;
						tok_d = b_dash2.tok;
						mode_d = b_dash2.match ? mtc_pkg::MODE_IDLE : mtc_pkg::MODE_BODY;
					end
					step.cnt = 3'd4;
				end
				mtc_pkg::MODE_BODY: begin
					step.res[0] = b_body.res;
					step.cnt = 3'd1;
					tok_d = b_body.tok;
					mode_d = b_body.match ? mtc_pkg::MODE_IDLE : mtc_pkg::MODE_BODY;
				end
				default: begin
					if (b == mtc_pkg::CH_LT) begin
						mode_d = mtc_pkg::MODE_P1;
					end else begin
						step.res[0] = mtc_pkg::mk_res(b, 1'b1, mtc_pkg::ROLE_TEXT, 1'b0,
							mtc_pkg::KIND_TEXT, 1'b0, 2'd0, 1'b0, 1'b0);
						step.cnt = 3'd1;
						mode_d = mtc_pkg::MODE_TEXT;
					end
				end
			endcase
		end
		cnt_m1 = step.cnt - 3'd1;
		for (int i = 0; i < mtc_pkg::MaxResults; i++) begin
			step.res[i].run_last = (cnt_m1 == 3'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mtc_pkg::MODE_IDLE;
			tok_q <= mtc_pkg::TOK_CLEAR;
		end else if (fire) begin
			mode_q <= mode_d;
			tok_q <= tok_d;
		end
	end

endmodule

>>> hw/rtl/mtc_obuf.sv
// Result register: holds the results of one transaction and hands them
// out one per cycle on the result channel while it is not stalled.
// Depends on mtc_pkg.
module mtc_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  mtc_pkg::step_out_t step,
	output logic               can_load,
	output logic               result_valid,
	input  logic               result_stall,
	output mtc_pkg::result_t   result
);

	mtc_pkg::result_t res_q [mtc_pkg::MaxResults];
	logic       valid_q;
	logic [1:0] idx_q;
	logic [1:0] last_q;
	logic       take;
	logic       last_take;
	logic [1:0] cnt_m1;

	assign take         = valid_q && !result_stall;
	assign last_take    = take && (idx_q == last_q);
	assign can_load     = !valid_q || last_take;
	assign result_valid = valid_q;
	assign result       = res_q[idx_q];
	assign cnt_m1       = step.cnt[1:0] - 2'd1;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < mtc_pkg::MaxResults; i++) begin
				res_q[i] <= step.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
			last_q <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= 2'd0;
			last_q <= cnt_m1;
		end else if (last_take) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

>>> hw/rtl/markup_token_classifier.sv
// Markup token classifier, top level: input register, step logic, result
// register and serializer. Depends on mtc_pkg, mtc_core, mtc_obuf.
//
// Takes one byte (or an end-of-input command) per item transaction and
// returns zero to four result transactions per item, in order, one per
// cycle while the output is not stalled; with a free output, an item is
// taken every cycle as long as each produces at most one result. An item
// producing more results holds the result register until its last result
// is taken, so the output serializer sets the rate. An item passes the
// input register and the step logic into the result register, which
// presents its first result. While the result register waits on a stalled
// output, the input register holds one more item and then the input stalls.
module markup_token_classifier (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mtc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output mtc_pkg::result_t result
);

	mtc_pkg::item_t     item_s1;
	logic               valid_s1;
	logic               can_load;
	logic               fire;
	logic               load;
	mtc_pkg::step_out_t step;

	assign fire       = valid_s1 && can_load;
	assign item_stall = valid_s1 && !can_load;
	assign load       = fire && (step.cnt != 3'd0);

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	mtc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.step   (step)
	);

	mtc_obuf u_obuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.step         (step),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_char |-> result.token_done)
		else $error("marker result without token_done");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == mtc_pkg::KIND_EOF) && !result.has_char
		|-> result.run_last && result.token_done)
		else $error("end-of-file marker not last of its transaction");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.run_last |=> result_valid)
		else $error("result run broken before its last transaction");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled while result register empty");
`endif

endmodule
